/* hw/rtl/adll_pkg.sv */
`timescale 1ns / 1ps

package adll_pkg;

  // Capacity of the list and the widths that follow from the field layout.
  localparam int unsigned MAX_BOXES       = 1024;
  localparam int unsigned MEM_DEPTH       = MAX_BOXES + 1;
  localparam int unsigned BOX_W           = 11;
  localparam int unsigned ACTION_W        = 3;
  localparam int unsigned SUM_W           = 20;
  localparam int unsigned BOX_COUNT_RESET = 1024;

  // Configuration port layout.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_COUNT = REG_IDX_W'(0);

  typedef enum logic [ACTION_W-1:0] {
    ACT_REBUILD     = 3'd0,
    ACT_MOVE_BEFORE = 3'd1,
    ACT_MOVE_AFTER  = 3'd2,
    ACT_SWAP        = 3'd3,
    ACT_TOGGLE      = 3'd4,
    ACT_REPORT      = 3'd5
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_MV_UNLINK,
    ST_MV_RDY,
    ST_MV_LINK1,
    ST_MV_LINK2,
    ST_SW_RDY,
    ST_SW_CHECK,
    ST_SW_W1,
    ST_SW_W2,
    ST_SW_W3,
    ST_SW_W4,
    ST_WALK,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_ACCEPT,
    CMD_DEC_REBUILD,
    CMD_DEC_MOVE,
    CMD_DEC_SWAP,
    CMD_TOGGLE,
    CMD_DEC_REPORT,
    CMD_SWEEP,
    CMD_UNLINK,
    CMD_RD_Y,
    CMD_LINK1,
    CMD_LINK2,
    CMD_SW_RDY,
    CMD_SW_CHECK,
    CMD_SW_W1,
    CMD_SW_W2,
    CMD_SW_W3,
    CMD_SW_W4,
    CMD_WALK,
    CMD_EMIT
  } dp_cmd_e;

  typedef struct packed {
    action_e action;
    logic    ok;
    logic    sweep_done;
    logic    adj;
    logic    walk_go;
    logic    out_free;
  } dp_status_t;

endpackage

/* hw/rtl/adll_dpath.sv */
`timescale 1ns / 1ps

module adll_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  adll_pkg::dp_cmd_e               cmd_i,
  input  logic [adll_pkg::BOX_W-1:0]      box_count_i,
  input  logic [adll_pkg::ACTION_W-1:0]   action_i,
  input  logic [adll_pkg::BOX_W-1:0]      first_box_i,
  input  logic [adll_pkg::BOX_W-1:0]      second_box_i,
  input  logic                            out_stall_i,
  output adll_pkg::dp_status_t            status_o,
  output logic                            out_valid_o,
  output logic [adll_pkg::SUM_W-1:0]      odd_position_sum_o
);

  localparam logic [adll_pkg::BOX_W-1:0] MaxBox = adll_pkg::BOX_W'(adll_pkg::MAX_BOXES);

  // Link tables: one write and one registered read per table per cycle.
  logic [adll_pkg::BOX_W-1:0] fwd_mem [adll_pkg::MEM_DEPTH];
  logic [adll_pkg::BOX_W-1:0] bwd_mem [adll_pkg::MEM_DEPTH];
  logic [adll_pkg::BOX_W-1:0] rd_f_q, rd_b_q;

  logic                       f_we, b_we;
  logic [adll_pkg::BOX_W-1:0] f_wa, f_wd, b_wa, b_wd, ra;

  logic [adll_pkg::ACTION_W-1:0] act_q;
  logic [adll_pkg::BOX_W-1:0]    x_q, y_q;
  logic [adll_pkg::BOX_W-1:0]    px_q, nx_q, py_q, ny_q;
  logic [adll_pkg::BOX_W-1:0]    left_q, right_q;
  logic [adll_pkg::BOX_W-1:0]    n_q, cnt_q;
  logic [adll_pkg::BOX_W-1:0]    nbuilt_q;
  logic                          before_q, reversed_q, parity_q;
  logic [adll_pkg::SUM_W-1:0]    sum_q, res_q;
  logic                          out_valid_q;

  logic [adll_pkg::BOX_W-1:0]    left_d, right_d, walk_box, clamp_n;
  logic [adll_pkg::SUM_W:0]      sum_ext;
  logic [adll_pkg::SUM_W-1:0]    sum_d;
  logic                          out_free;

  assign left_d   = before_q ? rd_b_q : y_q;
  assign right_d  = before_q ? y_q : rd_f_q;
  assign walk_box = reversed_q ? rd_b_q : rd_f_q;
  assign clamp_n  = (box_count_i > MaxBox) ? MaxBox : box_count_i;
  assign sum_ext  = {1'b0, sum_q} + (adll_pkg::SUM_W + 1)'(walk_box);
  assign sum_d    = sum_ext[adll_pkg::SUM_W] ? {adll_pkg::SUM_W{1'b1}}
                                             : sum_ext[adll_pkg::SUM_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.action     = adll_pkg::action_e'(act_q);
  assign status_o.ok         = (x_q != '0) && (x_q <= nbuilt_q) &&
                               (y_q != '0) && (y_q <= nbuilt_q) && (x_q != y_q);
  assign status_o.sweep_done = (cnt_q == n_q);
  assign status_o.adj        = (nx_q == y_q) || (px_q == y_q);
  assign status_o.walk_go    = (walk_box != '0) && (walk_box <= MaxBox) && (cnt_q < MaxBox);
  assign status_o.out_free   = out_free;

  // Table write and read address selection for each command.
  always_comb begin
    f_we = 1'b0;
    b_we = 1'b0;
    f_wa = x_q;
    f_wd = x_q;
    b_wa = x_q;
    b_wd = x_q;
    ra   = x_q;
    case (cmd_i)
      adll_pkg::CMD_SWEEP: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wa = cnt_q;
        b_wa = cnt_q;
        f_wd = (cnt_q == n_q) ? '0 : cnt_q + 1'b1;
        b_wd = (cnt_q == '0) ? n_q : cnt_q - 1'b1;
      end
      adll_pkg::CMD_UNLINK: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wa = rd_b_q;
        f_wd = rd_f_q;
        b_wa = rd_f_q;
        b_wd = rd_b_q;
      end
      adll_pkg::CMD_RD_Y, adll_pkg::CMD_SW_RDY: begin
        ra = y_q;
      end
      adll_pkg::CMD_LINK1: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wa = left_d;
        b_wa = right_d;
      end
      adll_pkg::CMD_LINK2: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wd = right_q;
        b_wd = left_q;
      end
      adll_pkg::CMD_SW_W1: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wa = px_q;
        f_wd = y_q;
        b_wa = nx_q;
        b_wd = y_q;
      end
      adll_pkg::CMD_SW_W2: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wa = y_q;
        f_wd = nx_q;
        b_wa = y_q;
        b_wd = px_q;
      end
      adll_pkg::CMD_SW_W3: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wa = py_q;
        b_wa = ny_q;
      end
      adll_pkg::CMD_SW_W4: begin
        f_we = 1'b1;
        b_we = 1'b1;
        f_wd = ny_q;
        b_wd = py_q;
      end
      adll_pkg::CMD_DEC_REPORT: begin
        ra = '0;
      end
      adll_pkg::CMD_WALK: begin
        ra = walk_box;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fwd_mem[f_wa] <= f_wd;
    end
    rd_f_q <= fwd_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bwd_mem[b_wa] <= b_wd;
    end
    rd_b_q <= bwd_mem[ra];
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      adll_pkg::CMD_ACCEPT: begin
        act_q <= action_i;
        x_q   <= first_box_i;
        y_q   <= second_box_i;
      end
      adll_pkg::CMD_DEC_REBUILD: begin
        n_q   <= clamp_n;
        cnt_q <= '0;
      end
      adll_pkg::CMD_DEC_MOVE: begin
        before_q <= (adll_pkg::action_e'(act_q) == adll_pkg::ACT_MOVE_BEFORE) != reversed_q;
      end
      adll_pkg::CMD_SWEEP: begin
        cnt_q <= cnt_q + 1'b1;
      end
      adll_pkg::CMD_LINK1: begin
        left_q  <= left_d;
        right_q <= right_d;
      end
      adll_pkg::CMD_SW_RDY: begin
        px_q <= rd_b_q;
        nx_q <= rd_f_q;
      end
      adll_pkg::CMD_SW_CHECK: begin
        py_q     <= rd_b_q;
        ny_q     <= rd_f_q;
        // A neighbor on the right is a move after, otherwise a move before.
        before_q <= (nx_q != y_q);
      end
      adll_pkg::CMD_DEC_REPORT: begin
        sum_q    <= '0;
        parity_q <= 1'b0;
        cnt_q    <= '0;
      end
      adll_pkg::CMD_WALK: begin
        if (status_o.walk_go) begin
          if (!parity_q) begin
            sum_q <= sum_d;
          end
          parity_q <= !parity_q;
          cnt_q    <= cnt_q + 1'b1;
        end
      end
      adll_pkg::CMD_EMIT: begin
        res_q <= sum_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reversed_q  <= 1'b0;
      nbuilt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == adll_pkg::CMD_DEC_REBUILD) begin
        reversed_q <= 1'b0;
        nbuilt_q   <= clamp_n;
      end else if (cmd_i == adll_pkg::CMD_TOGGLE) begin
        reversed_q <= !reversed_q;
      end
      if (cmd_i == adll_pkg::CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign odd_position_sum_o = res_q;

endmodule

/* hw/rtl/adll_ctrl.sv */
`timescale 1ns / 1ps

module adll_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  adll_pkg::dp_status_t status_i,
  output adll_pkg::dp_cmd_e    cmd_o
);

  adll_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adll_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      adll_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = adll_pkg::ST_DECODE;
        end
      end
      adll_pkg::ST_DECODE: begin
        case (status_i.action)
          adll_pkg::ACT_REBUILD: state_d = adll_pkg::ST_SWEEP;
          adll_pkg::ACT_MOVE_BEFORE, adll_pkg::ACT_MOVE_AFTER: begin
            state_d = status_i.ok ? adll_pkg::ST_MV_UNLINK : adll_pkg::ST_IDLE;
          end
          adll_pkg::ACT_SWAP: begin
            state_d = status_i.ok ? adll_pkg::ST_SW_RDY : adll_pkg::ST_IDLE;
          end
          adll_pkg::ACT_REPORT: state_d = adll_pkg::ST_WALK;
          default:              state_d = adll_pkg::ST_IDLE;
        endcase
      end
      adll_pkg::ST_SWEEP: begin
        if (status_i.sweep_done) begin
          state_d = adll_pkg::ST_IDLE;
        end
      end
      adll_pkg::ST_MV_UNLINK: state_d = adll_pkg::ST_MV_RDY;
      adll_pkg::ST_MV_RDY:    state_d = adll_pkg::ST_MV_LINK1;
      adll_pkg::ST_MV_LINK1:  state_d = adll_pkg::ST_MV_LINK2;
      adll_pkg::ST_MV_LINK2:  state_d = adll_pkg::ST_IDLE;
      adll_pkg::ST_SW_RDY:    state_d = adll_pkg::ST_SW_CHECK;
      adll_pkg::ST_SW_CHECK: begin
        state_d = status_i.adj ? adll_pkg::ST_MV_UNLINK : adll_pkg::ST_SW_W1;
      end
      adll_pkg::ST_SW_W1: state_d = adll_pkg::ST_SW_W2;
      adll_pkg::ST_SW_W2: state_d = adll_pkg::ST_SW_W3;
      adll_pkg::ST_SW_W3: state_d = adll_pkg::ST_SW_W4;
      adll_pkg::ST_SW_W4: state_d = adll_pkg::ST_IDLE;
      adll_pkg::ST_WALK: begin
        if (!status_i.walk_go) begin
          state_d = adll_pkg::ST_EMIT;
        end
      end
      adll_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = adll_pkg::ST_IDLE;
        end
      end
      default: state_d = adll_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = adll_pkg::CMD_IDLE;
    case (state_q)
      adll_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o = adll_pkg::CMD_ACCEPT;
        end
      end
      adll_pkg::ST_DECODE: begin
        case (status_i.action)
          adll_pkg::ACT_REBUILD: cmd_o = adll_pkg::CMD_DEC_REBUILD;
          adll_pkg::ACT_MOVE_BEFORE, adll_pkg::ACT_MOVE_AFTER: begin
            cmd_o = status_i.ok ? adll_pkg::CMD_DEC_MOVE : adll_pkg::CMD_IDLE;
          end
          adll_pkg::ACT_SWAP: begin
            cmd_o = status_i.ok ? adll_pkg::CMD_DEC_SWAP : adll_pkg::CMD_IDLE;
          end
          adll_pkg::ACT_TOGGLE: cmd_o = adll_pkg::CMD_TOGGLE;
          adll_pkg::ACT_REPORT: cmd_o = adll_pkg::CMD_DEC_REPORT;
          default:              cmd_o = adll_pkg::CMD_IDLE;
        endcase
      end
      adll_pkg::ST_SWEEP:     cmd_o = adll_pkg::CMD_SWEEP;
      adll_pkg::ST_MV_UNLINK: cmd_o = adll_pkg::CMD_UNLINK;
      adll_pkg::ST_MV_RDY:    cmd_o = adll_pkg::CMD_RD_Y;
      adll_pkg::ST_MV_LINK1:  cmd_o = adll_pkg::CMD_LINK1;
      adll_pkg::ST_MV_LINK2:  cmd_o = adll_pkg::CMD_LINK2;
      adll_pkg::ST_SW_RDY:    cmd_o = adll_pkg::CMD_SW_RDY;
      adll_pkg::ST_SW_CHECK:  cmd_o = adll_pkg::CMD_SW_CHECK;
      adll_pkg::ST_SW_W1:     cmd_o = adll_pkg::CMD_SW_W1;
      adll_pkg::ST_SW_W2:     cmd_o = adll_pkg::CMD_SW_W2;
      adll_pkg::ST_SW_W3:     cmd_o = adll_pkg::CMD_SW_W3;
      adll_pkg::ST_SW_W4:     cmd_o = adll_pkg::CMD_SW_W4;
      adll_pkg::ST_WALK:      cmd_o = adll_pkg::CMD_WALK;
      adll_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o = adll_pkg::CMD_EMIT;
        end
      end
      default: cmd_o = adll_pkg::CMD_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != adll_pkg::ST_IDLE);

endmodule

/* hw/rtl/array_doubly_linked_list_engine_top.sv */
`timescale 1ns / 1ps

// Circular doubly linked list of boxes 1..N kept in two link tables (forward and
// backward, 1025 entries each, in block memory) with entry 0 as the head sentinel.
// Each input word carries an action and two box numbers: rebuild (lay out boxes
// 1..box_count in order and clear the reversed flag; it must come before any other
// action), move a box before or after another, swap two boxes, toggle the reading
// direction, or report the sum of the boxes at odd positions in the current order.
// Only a report produces an output word. Moves and swaps that name a box outside
// the current list, or the same box twice, change nothing. One input word is worked
// on at a time and in_stall_o stays high until it is done; every link update is a
// dependent read or write on the write port or the registered read port of each
// table. A swap of two neighboring boxes is done as a move; a rebuild and a report
// step through the list one box at a time, and a report also waits for the output
// register while a previous sum still sits unread. The link tables are not cleared
// by reset; a report before the first rebuild returns an undefined sum. The box_count
// register sits at byte address 0 of the APB port (reset value 1024, values above
// 1024 build 1024 boxes); write it only while idle.

module array_doubly_linked_list_engine_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [adll_pkg::PADDR_W-1:0]      paddr,
  input  logic [adll_pkg::DATA_W-1:0]       pwdata,
  output logic [adll_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [adll_pkg::ACTION_W-1:0]     action_i,
  input  logic [adll_pkg::BOX_W-1:0]        first_box_i,
  input  logic [adll_pkg::BOX_W-1:0]        second_box_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [adll_pkg::SUM_W-1:0]        odd_position_sum_o
);

  logic [adll_pkg::BOX_W-1:0]     box_count_q;
  logic [adll_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           reg_write;
  adll_pkg::dp_cmd_e              cmd;
  adll_pkg::dp_status_t           status;

  // The register index is the word address; the byte offset bits are ignored.
  assign reg_idx   = paddr[adll_pkg::PADDR_W-1:2];
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_count_q <= adll_pkg::BOX_W'(adll_pkg::BOX_COUNT_RESET);
    end else if (reg_write && (reg_idx == adll_pkg::REG_BOX_COUNT)) begin
      box_count_q <= pwdata[adll_pkg::BOX_W-1:0];
    end
  end

  // Reads of an address beyond the register list return zero.
  assign prdata = (reg_idx == adll_pkg::REG_BOX_COUNT)
                  ? adll_pkg::DATA_W'(box_count_q) : '0;

  // The controller sequences each action; the datapath owns the link tables,
  // the working registers and the output register.
  adll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adll_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .box_count_i        (box_count_q),
    .action_i           (action_i),
    .first_box_i        (first_box_i),
    .second_box_i       (second_box_i),
    .out_stall_i        (out_stall_i),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .odd_position_sum_o (odd_position_sum_o)
  );

endmodule
